### sv/frc_pkg.sv
// Shared constants and types for the frustum cull test block.
// Used by frc_eval and frustum_cull_test; depends on nothing.
package frc_pkg;
	localparam int NUM_PLANES = 6;
	localparam int NUM_COEFFS = 4;
	localparam int FRAC_BITS  = 16;
	localparam int ARG_W      = 32;
	localparam int COEFF_W    = ARG_W + 1;
	localparam int ROW_W      = NUM_COEFFS * COEFF_W;
	localparam int ROW_AW     = $clog2(NUM_PLANES);
	localparam int CNT_W      = $clog2(NUM_PLANES + 1);
	localparam int PROD_W     = ARG_W + COEFF_W;
	localparam int ACC_W      = PROD_W + 3;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SPHERE = 2'd1;
	localparam logic [1:0] OP_BOX    = 2'd2;

	// Control that travels with one plane row into the evaluator
	typedef struct packed {
		logic vld;
		logic box;
		logic last;
	} evctl_t;
endpackage

### sv/frc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module frc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### sv/frc_eval.sv
// Plane evaluator: multiplies one plane row against the item, then sums and signs it.
// Depends on frc_pkg.
module frc_eval import frc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  evctl_t                  ctl,
	input  logic [ROW_W-1:0]        row,
	input  logic signed [ARG_W-1:0] args [6],
	output evctl_t                  ctl_out,
	output logic                    not_pos
);
	logic signed [COEFF_W-1:0] n [NUM_COEFFS];
	logic signed [PROD_W-1:0]  p [3];
	logic signed [PROD_W-1:0]  h [3];
	logic signed [PROD_W-1:0]  p_s2 [3];
	logic signed [PROD_W-1:0]  h_s2 [3];
	logic signed [COEFF_W-1:0] d_s2;
	logic signed [ARG_W-1:0]   r_s2;
	evctl_t                    ctl_s2;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   d_ext;
	logic signed [ACC_W-1:0]   r_ext;

	// Split the row and form the products
	always_comb begin
		for (int k = 0; k < NUM_COEFFS; k++) begin
			n[k] = row[k*COEFF_W +: COEFF_W];
		end
		for (int k = 0; k < 3; k++) begin
			p[k] = PROD_W'(args[k]) * PROD_W'(n[k]);
			h[k] = PROD_W'(args[3+k]) * PROD_W'(n[k]);
			if (h[k][PROD_W-1]) begin
				h[k] = -h[k];
			end
		end
	end

	// Register products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			p_s2[k] <= p[k];
			h_s2[k] <= h[k];
		end
		d_s2 <= n[3];
		r_s2 <= args[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	// Sum the plane value and test for not positive
	always_comb begin
		d_ext = {{(ACC_W-COEFF_W-FRAC_BITS){d_s2[COEFF_W-1]}}, d_s2, {FRAC_BITS{1'b0}}};
		r_ext = {{(ACC_W-ARG_W-FRAC_BITS){r_s2[ARG_W-1]}}, r_s2, {FRAC_BITS{1'b0}}};
		acc = d_ext;
		for (int k = 0; k < 3; k++) begin
			acc = acc + {{(ACC_W-PROD_W){p_s2[k][PROD_W-1]}}, p_s2[k]};
		end
		if (ctl_s2.box) begin
			for (int k = 0; k < 3; k++) begin
				acc = acc + {{(ACC_W-PROD_W){1'b0}}, h_s2[k]};
			end
		end else begin
			acc = acc + r_ext;
		end
		not_pos = acc[ACC_W-1] || (acc == '0);
	end

	assign ctl_out = ctl_s2;
endmodule

### sv/frustum_cull_test.sv
// Frustum cull test top level: plane store, sequencer and result register.
// Depends on frc_pkg, frc_ram and frc_eval.
//
// The six clip planes live in a RAM of six rows, one row of four 33-bit
// coefficients per plane, cleared at reset by one valid bit per row. A load
// reads and rewrites each row in turn. A sphere or box test streams the six
// rows through the evaluator, one plane per cycle. An unused operation code
// goes straight to the result, with visible and was_test clear. One item is
// worked at a time; a finished result sits in the output register, so the
// next item is taken while it waits.
module frustum_cull_test import frc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// column_index[1:0], arg0[33:2], arg1[65:34], arg2[97:66], arg3[129:98],
	// arg4[161:130], arg5[193:162], zero fill
	input  logic [199:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// visible[0], zero fill
	output logic [7:0]   m_tdata,
	// was_test[0]
	output logic         m_tuser
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_TEST = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]              state_q;
	logic [1:0]              op_q;
	logic [1:0]              col_q;
	logic signed [ARG_W-1:0] args_q [6];
	logic [CNT_W-1:0]        iss_q;
	logic                    rd_s1;
	logic [ROW_AW-1:0]       rrow_s1;
	logic                    rvld_s1;
	logic [NUM_PLANES-1:0]   row_vld_q;
	logic                    culled_q;
	logic                    res_vis_q;
	logic                    res_test_q;
	logic                    m_vis_q;
	logic                    m_test_q;
	logic                    m_valid_q;

	logic                    re;
	logic [ROW_AW-1:0]       raddr;
	logic [ROW_W-1:0]        rdata;
	logic [ROW_W-1:0]        row;
	logic                    we;
	logic [ROW_W-1:0]        wdata;
	logic signed [ARG_W-1:0] ai;
	logic signed [COEFF_W-1:0] newc;
	evctl_t                  ctl_in;
	evctl_t                  ctl_out;
	logic                    not_pos;
	logic                    out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_tready;

	// Issue row reads while planes remain
	assign re    = ((state_q == ST_LOAD) || (state_q == ST_TEST)) &&
		(iss_q < CNT_W'(NUM_PLANES));
	assign raddr = iss_q[ROW_AW-1:0];

	// Mask rows never written to zero
	assign row = rvld_s1 ? rdata : '0;

	// Build the rewritten row for a load
	always_comb begin
		case (rrow_s1[ROW_AW-1:1])
			2'd0:    ai = args_q[0];
			2'd1:    ai = args_q[1];
			default: ai = args_q[2];
		endcase
		if (rrow_s1[0]) begin
			newc = COEFF_W'(args_q[3]) + COEFF_W'(ai);
		end else begin
			newc = COEFF_W'(args_q[3]) - COEFF_W'(ai);
		end
		wdata = row;
		wdata[col_q*COEFF_W +: COEFF_W] = newc;
	end

	assign we = rd_s1 && (state_q == ST_LOAD);

	frc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_PLANES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (rrow_s1),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ctl_in.vld  = rd_s1 && (state_q == ST_TEST);
	assign ctl_in.box  = (op_q == OP_BOX);
	assign ctl_in.last = (rrow_s1 == ROW_AW'(NUM_PLANES - 1));

	frc_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_in),
		.row     (row),
		.args    (args_q),
		.ctl_out (ctl_out),
		.not_pos (not_pos)
	);

	// Capture the item
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			col_q <= s_tdata[1:0];
			for (int k = 0; k < 6; k++) begin
				args_q[k] <= s_tdata[2 + k*ARG_W +: ARG_W];
			end
		end
		rrow_s1 <= raddr;
	end

	// Sequencer, plane valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_LOAD;
			iss_q      <= '0;
			rd_s1      <= 1'b0;
			rvld_s1    <= 1'b0;
			row_vld_q  <= '0;
			culled_q   <= 1'b0;
			res_vis_q  <= 1'b0;
			res_test_q <= 1'b0;
			m_vis_q    <= 1'b0;
			m_test_q   <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			rd_s1   <= re;
			rvld_s1 <= row_vld_q[raddr];
			if (re) begin
				iss_q <= iss_q + 1'b1;
			end
			if (we) begin
				row_vld_q[rrow_s1] <= 1'b1;
			end
			// Drop a taken result unless a new one replaces it
			if (m_valid_q && m_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q     <= s_tuser;
						iss_q    <= '0;
						culled_q <= 1'b0;
						case (s_tuser)
							OP_LOAD:          state_q <= ST_LOAD;
							OP_SPHERE, OP_BOX: state_q <= ST_TEST;
							default: begin
								res_vis_q  <= 1'b0;
								res_test_q <= 1'b0;
								state_q    <= ST_DONE;
							end
						endcase
					end
				end
				ST_LOAD: begin
					if (we && ctl_in.last) begin
						res_vis_q  <= 1'b0;
						res_test_q <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_TEST: begin
					if (ctl_out.vld) begin
						culled_q <= culled_q || not_pos;
						if (ctl_out.last) begin
							res_vis_q  <= !(culled_q || not_pos);
							res_test_q <= 1'b1;
							state_q    <= ST_DONE;
						end
					end
				end
				default: begin
					if (out_free) begin
						m_vis_q   <= res_vis_q;
						m_test_q  <= res_test_q;
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_vis_q};
	assign m_tuser  = m_test_q;
endmodule
